// File: src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and the command type of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int MAX_PAYLOAD  = 1024;
   localparam int QUEUE_DEPTH  = 4;

   localparam int SEQ_W  = 32;
   localparam int TAG_W  = 32;
   localparam int LEN_W  = 11;
   localparam int TMR_W  = 16;
   localparam int KIND_W = 3;
   localparam int FUNC_W = 2;

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int QP_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(1000);

   localparam logic [FUNC_W-1:0] FUNC_NEW  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SEND        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RESEND      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REFUSE_FULL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REFUSE_FIN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_COMPLETE    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ACK_TAKEN   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ACK_DROP    = 3'd6;

   // walk = 0: one result from the fields; walk = 1: resend count slots from slot
   typedef struct packed {
      logic              walk;
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic              link;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  count;
   } gbn_cmd_type;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(WINDOW_DEPTH - 1)) r = '0;
      else                               r = s + SLOT_W'(1);
      return r;
   endfunction

endpackage

// File: src/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Accepts requests, keeps the window and timer state, emits commands.
// ----------------------------------------------------------------------------
module gbn_front
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [TAG_W-1:0]  req_payload_tag,
   input  logic [LEN_W-1:0]  req_payload_len,
   input  logic              req_link_sel,
   input  logic [SEQ_W-1:0]  req_ack_seq,
   input  logic              req_ack_good,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TMR_W-1:0]  csr_data,
   input  logic              q_full,
   output logic              q_push,
   output gbn_cmd_type       q_cmd
);

   logic [TMR_W-1:0]  timeout_ff, timeout_in;
   logic [SEQ_W-1:0]  base_ff, base_in;
   logic [SEQ_W-1:0]  next_ff, next_in;
   logic [SEQ_W-1:0]  fseq_ff, fseq_in;
   logic              fsent_ff, fsent_in;
   logic              facked_ff, facked_in;
   logic              trun_ff, trun_in;
   logic [TMR_W-1:0]  tcnt_ff, tcnt_in;
   logic [SLOT_W-1:0] bslot_ff, bslot_in;
   logic [SLOT_W-1:0] nslot_ff, nslot_in;

   logic              accept;
   logic [SEQ_W-1:0]  span, step, ack_p1;
   logic [CNT_W:0]    slot_sum;
   logic [LEN_W-1:0]  len_sat;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign span     = next_ff - base_ff;
   assign ack_p1   = req_ack_seq + SEQ_W'(1);
   assign step     = ack_p1 - base_ff;
   // step is at most the window depth whenever it is used
   assign slot_sum = (CNT_W+1)'(bslot_ff) + (CNT_W+1)'(step[CNT_W-1:0]);
   assign len_sat  = (32'(req_payload_len) > 32'(MAX_PAYLOAD)) ?
                     LEN_W'(MAX_PAYLOAD) : req_payload_len;

   always_comb begin
      timeout_in = timeout_ff;
      base_in    = base_ff;
      next_in    = next_ff;
      fseq_in    = fseq_ff;
      fsent_in   = fsent_ff;
      facked_in  = facked_ff;
      trun_in    = trun_ff;
      tcnt_in    = tcnt_ff;
      bslot_in   = bslot_ff;
      nslot_in   = nslot_ff;
      q_push     = 1'b0;
      q_cmd      = '0;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      if (accept) begin
         unique case (req_func)
            FUNC_NEW: begin
               q_push = 1'b1;
               if (fsent_ff) begin
                  q_cmd.kind = KIND_REFUSE_FIN;
               end else if (span >= SEQ_W'(WINDOW_DEPTH)) begin
                  q_cmd.kind = KIND_REFUSE_FULL;
               end else begin
                  q_cmd.kind = KIND_SEND;
                  q_cmd.seq  = next_ff;
                  q_cmd.link = req_link_sel;
                  q_cmd.tag  = req_payload_tag;
                  q_cmd.len  = len_sat;
                  q_cmd.slot = nslot_ff;
                  if (len_sat == '0) begin
                     fsent_in = 1'b1;
                     fseq_in  = next_ff;
                  end
                  if (base_ff == next_ff) begin
                     trun_in = 1'b1;
                     tcnt_in = timeout_ff;
                  end
                  next_in  = next_ff + SEQ_W'(1);
                  nslot_in = slot_next(nslot_ff);
               end
            end
            FUNC_ACK: begin
               q_push    = 1'b1;
               q_cmd.seq = req_ack_seq;
               if (!req_ack_good) begin
                  q_cmd.kind = KIND_ACK_DROP;
               end else if (facked_ff || (fsent_ff && fseq_ff == req_ack_seq)) begin
                  q_cmd.kind = KIND_COMPLETE;
                  facked_in  = 1'b1;
                  trun_in    = 1'b0;
                  tcnt_in    = '0;
               end else begin
                  q_cmd.kind = KIND_ACK_TAKEN;
                  if (step != '0 && step <= span) begin
                     base_in = ack_p1;
                     if (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH))
                        bslot_in = SLOT_W'(slot_sum - (CNT_W+1)'(WINDOW_DEPTH));
                     else
                        bslot_in = SLOT_W'(slot_sum);
                  end
                  if (base_in == next_ff) begin
                     trun_in = 1'b0;
                     tcnt_in = '0;
                  end else begin
                     trun_in = 1'b1;
                     tcnt_in = timeout_ff;
                  end
               end
            end
            FUNC_TICK: begin
               if (trun_ff && !facked_ff) begin
                  if (tcnt_ff > TMR_W'(1)) begin
                     tcnt_in = tcnt_ff - TMR_W'(1);
                  end else begin
                     tcnt_in = timeout_ff;
                     if (span != '0) begin
                        q_push      = 1'b1;
                        q_cmd.walk  = 1'b1;
                        q_cmd.kind  = KIND_RESEND;
                        q_cmd.seq   = base_ff;
                        q_cmd.slot  = bslot_ff;
                        q_cmd.count = (span > SEQ_W'(WINDOW_DEPTH)) ?
                                      CNT_W'(WINDOW_DEPTH) : span[CNT_W-1:0];
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         base_ff    <= SEQ_W'(1);
         next_ff    <= SEQ_W'(1);
         fseq_ff    <= '0;
         fsent_ff   <= 1'b0;
         facked_ff  <= 1'b0;
         trun_ff    <= 1'b0;
         tcnt_ff    <= '0;
         bslot_ff   <= '0;
         nslot_ff   <= '0;
      end else begin
         timeout_ff <= timeout_in;
         base_ff    <= base_in;
         next_ff    <= next_in;
         fseq_ff    <= fseq_in;
         fsent_ff   <= fsent_in;
         facked_ff  <= facked_in;
         trun_ff    <= trun_in;
         tcnt_ff    <= tcnt_in;
         bslot_ff   <= bslot_in;
         nslot_ff   <= nslot_in;
      end
   end

endmodule

// File: src/gbn_cmd_queue.sv
// ----------------------------------------------------------------------------
// gbn_cmd_queue
// Small FIFO of commands between the front and the back.
// ----------------------------------------------------------------------------
module gbn_cmd_queue
   import gbn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  gbn_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        pop_valid,
   output gbn_cmd_type pop_cmd
);

   gbn_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wp_ff, wp_in;
   logic [QP_W-1:0]  rp_ff, rp_in;
   logic [QC_W-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   function automatic logic [QP_W-1:0] qp_next(input logic [QP_W-1:0] p);
      logic [QP_W-1:0] r;
      if (p == QP_W'(QUEUE_DEPTH - 1)) r = '0;
      else                            r = p + QP_W'(1);
      return r;
   endfunction

   assign full      = (cnt_ff == QC_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = slot_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wp_in  = do_push ? qp_next(wp_ff) : wp_ff;
      rp_in  = do_pop  ? qp_next(rp_ff) : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + QC_W'(1);
      if (!do_push && do_pop) cnt_in = cnt_ff - QC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: src/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Executes commands: stores sent descriptors, walks the window on resend,
// drives the registered response channel.
// ----------------------------------------------------------------------------
module gbn_back
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  gbn_cmd_type       q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SEQ_W-1:0]  rsp_seq_out,
   output logic              rsp_link_out,
   output logic [TAG_W-1:0]  rsp_tag_out,
   output logic [LEN_W-1:0]  rsp_len_out,
   output logic              rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   localparam int ENT_W = TAG_W + LEN_W;

   logic [ENT_W-1:0]  mem [WINDOW_DEPTH];
   logic [ENT_W-1:0]  rd_ff;

   logic              state_ff, state_in;
   logic [SEQ_W-1:0]  cseq_ff, cseq_in;
   logic [SLOT_W-1:0] cslot_ff, cslot_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;

   logic              vld_ff, vld_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              link_ff, link_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              last_ff, last_in;

   logic              out_free, load;
   logic              rd_en, wr_en;
   logic [SLOT_W-1:0] rd_addr;

   assign out_free = !vld_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cseq_in   = cseq_ff;
      cslot_in  = cslot_ff;
      remain_in = remain_ff;
      q_pop     = 1'b0;
      load      = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cslot_ff;
      wr_en     = 1'b0;
      kind_in   = kind_ff;
      seq_in    = seq_ff;
      link_in   = link_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      last_in   = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_cmd.walk) begin
               // first read issues now into rd_ff; the walk state turns it into a result
               q_pop     = 1'b1;
               rd_en     = 1'b1;
               rd_addr   = q_cmd.slot;
               cseq_in   = q_cmd.seq;
               cslot_in  = slot_next(q_cmd.slot);
               remain_in = q_cmd.count;
               state_in  = ST_WALK;
            end else if (q_valid && out_free) begin
               q_pop   = 1'b1;
               load    = 1'b1;
               wr_en   = (q_cmd.kind == KIND_SEND);
               kind_in = q_cmd.kind;
               seq_in  = q_cmd.seq;
               link_in = q_cmd.link;
               tag_in  = q_cmd.tag;
               len_in  = q_cmd.len;
               last_in = 1'b1;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = KIND_RESEND;
               seq_in  = cseq_ff;
               link_in = 1'b0;
               tag_in  = rd_ff[ENT_W-1:LEN_W];
               len_in  = rd_ff[LEN_W-1:0];
               last_in = (remain_ff == CNT_W'(1));
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  cslot_in  = slot_next(cslot_ff);
                  cseq_in   = cseq_ff + SEQ_W'(1);
                  remain_in = remain_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load)          vld_in = 1'b1;
      else if (out_free) vld_in = 1'b0;
      else               vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[q_cmd.slot] <= {q_cmd.tag, q_cmd.len};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cseq_ff   <= cseq_in;
      cslot_ff  <= cslot_in;
      remain_ff <= remain_in;
      kind_ff   <= kind_in;
      seq_ff    <= seq_in;
      link_ff   <= link_in;
      tag_ff    <= tag_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_seq_out  = seq_ff;
   assign rsp_link_out = link_ff;
   assign rsp_tag_out  = tag_ff;
   assign rsp_len_out  = len_ff;
   assign rsp_last     = last_ff;

endmodule

// File: src/go_back_n_sender_window_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N sender window: numbers and stores packet descriptors, slides
// the window on good acks, resends the whole window on timer expiry.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          carries
//  req_     in         valid / stall      one request: new packet, ack or tick
//  rsp_     out        valid / stall      up to one result per cycle, held while stalled; last marks end
//  csr_     in         valid / ready      timeout_ticks write
//
// The front takes a request every cycle while the command queue has room
// and updates window/timer state in that cycle. The back turns a command
// into results: a single result is loaded into the output register, a
// resend of N slots reads the window RAM once per result. Reset is
// synchronous; the window RAM is not cleared. A stall on rsp_ holds the
// output register; the queue absorbs up to four commands before req_stall.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [TAG_W-1:0]  req_payload_tag,
   input  logic [LEN_W-1:0]  req_payload_len,
   input  logic              req_link_sel,
   input  logic [SEQ_W-1:0]  req_ack_seq,
   input  logic              req_ack_good,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SEQ_W-1:0]  rsp_seq_out,
   output logic              rsp_link_out,
   output logic [TAG_W-1:0]  rsp_tag_out,
   output logic [LEN_W-1:0]  rsp_len_out,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TMR_W-1:0]  csr_data
);

   // front -> queue
   logic        q_full, q_push;
   gbn_cmd_type q_push_cmd;
   // queue -> back
   logic        q_pop, q_valid;
   gbn_cmd_type q_pop_cmd;

   gbn_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_payload_tag (req_payload_tag),
      .req_payload_len (req_payload_len),
      .req_link_sel    (req_link_sel),
      .req_ack_seq     (req_ack_seq),
      .req_ack_good    (req_ack_good),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (q_push_cmd)
   );

   // commands stay in request order, so a resend walk always sees
   // every earlier send already written into the window RAM
   gbn_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_pop_cmd)
   );

   gbn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_pop_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_seq_out  (rsp_seq_out),
      .rsp_link_out (rsp_link_out),
      .rsp_tag_out  (rsp_tag_out),
      .rsp_len_out  (rsp_len_out),
      .rsp_last     (rsp_last)
   );

endmodule

// File: test/gbn_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbn_window_checker
// Passive watcher for the Go-Back-N sender: tracks window and timer state
// from accepted requests and csr writes, queues the transmissions each
// request should cause and compares them in order with the rsp_ channel.
// ----------------------------------------------------------------------------
module gbn_window_checker
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [TAG_W-1:0]  req_payload_tag,
   input  logic [LEN_W-1:0]  req_payload_len,
   input  logic              req_link_sel,
   input  logic [SEQ_W-1:0]  req_ack_seq,
   input  logic              req_ack_good,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [KIND_W-1:0] rsp_kind,
   input  logic [SEQ_W-1:0]  rsp_seq_out,
   input  logic              rsp_link_out,
   input  logic [TAG_W-1:0]  rsp_tag_out,
   input  logic [LEN_W-1:0]  rsp_len_out,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [TMR_W-1:0]  csr_data,
   output int                mismatches,
   output int                owed,
   output logic [SEQ_W-1:0]  base_seen,
   output logic [SEQ_W-1:0]  next_seen
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic              link;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
      logic              last;
   } tx_result_type;

   tx_result_type     due[$];
   logic [TMR_W-1:0]  timeout_ticks;
   logic [SEQ_W-1:0]  win_base;
   logic [SEQ_W-1:0]  seq_next;
   logic [SEQ_W-1:0]  final_seq;
   logic              fin_sent;
   logic              fin_acked;
   logic              timer_on;
   logic [TMR_W-1:0]  timer_left;
   logic [TAG_W-1:0]  slot_tag [WINDOW_DEPTH];
   logic [LEN_W-1:0]  slot_len [WINDOW_DEPTH];

   function automatic void owe(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq, logic link,
                               logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic last);
      tx_result_type r;
      r.kind = kind;
      r.seq  = seq;
      r.link = link;
      r.tag  = tag;
      r.len  = len;
      r.last = last;
      due.push_back(r);
   endfunction

   function automatic void arm_timer();
      timer_on   = 1'b1;
      timer_left = timeout_ticks;
   endfunction

   function automatic void step_window(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tag,
                                       logic [LEN_W-1:0] len, logic link,
                                       logic [SEQ_W-1:0] ack, logic good);
      logic [SEQ_W-1:0]  span;
      logic [SEQ_W-1:0]  adv;
      logic [SEQ_W-1:0]  s;
      int unsigned       n;
      int unsigned       i;
      logic [SLOT_W-1:0] idx;
      span = seq_next - win_base;
      case (func)
         FUNC_NEW: begin
            if (fin_sent) begin
               owe(KIND_REFUSE_FIN, '0, 1'b0, '0, '0, 1'b1);
            end else if (span >= SEQ_W'(WINDOW_DEPTH)) begin
               owe(KIND_REFUSE_FULL, '0, 1'b0, '0, '0, 1'b1);
            end else begin
               if (len > LEN_W'(MAX_PAYLOAD)) len = LEN_W'(MAX_PAYLOAD);
               idx = SLOT_W'((seq_next - SEQ_W'(1)) % WINDOW_DEPTH);
               slot_tag[idx] = tag;
               slot_len[idx] = len;
               owe(KIND_SEND, seq_next, link, tag, len, 1'b1);
               if (len == '0) begin
                  fin_sent  = 1'b1;
                  final_seq = seq_next;
               end
               if (span == '0) arm_timer();
               seq_next = seq_next + SEQ_W'(1);
            end
         end
         FUNC_ACK: begin
            if (!good) begin
               owe(KIND_ACK_DROP, ack, 1'b0, '0, '0, 1'b1);
            end else if (fin_acked || (fin_sent && final_seq == ack)) begin
               fin_acked  = 1'b1;
               timer_on   = 1'b0;
               timer_left = '0;
               owe(KIND_COMPLETE, ack, 1'b0, '0, '0, 1'b1);
            end else begin
               // serial-order check: slide only forward and not past next_seq
               adv = ack + SEQ_W'(1) - win_base;
               if (adv != '0 && adv <= span) win_base = ack + SEQ_W'(1);
               if (win_base == seq_next) begin
                  timer_on   = 1'b0;
                  timer_left = '0;
               end else begin
                  arm_timer();
               end
               owe(KIND_ACK_TAKEN, ack, 1'b0, '0, '0, 1'b1);
            end
         end
         FUNC_TICK: begin
            if (timer_on && !fin_acked) begin
               if (timer_left > TMR_W'(1)) begin
                  timer_left = timer_left - TMR_W'(1);
               end else begin
                  arm_timer();
                  n = (span > SEQ_W'(WINDOW_DEPTH)) ? WINDOW_DEPTH : span;
                  for (i = 0; i < n; i++) begin
                     s   = win_base + SEQ_W'(i);
                     idx = SLOT_W'((s - SEQ_W'(1)) % WINDOW_DEPTH);
                     owe(KIND_RESEND, s, 1'b0, slot_tag[idx], slot_len[idx], i + 1 == n);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic bit field_ok(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void check_result();
      tx_result_type w;
      if (due.size() == 0) begin
         $error("unexpected result: kind %0d seq 0x%0h", rsp_kind, rsp_seq_out);
         mismatches++;
      end else begin
         w = due.pop_front();
         if (!field_ok("kind", SEQ_W'(w.kind), SEQ_W'(rsp_kind))) mismatches++;
         if (!field_ok("seq_out", w.seq, rsp_seq_out)) mismatches++;
         if (!field_ok("link_out", SEQ_W'(w.link), SEQ_W'(rsp_link_out))) mismatches++;
         if (!field_ok("tag_out", w.tag, rsp_tag_out)) mismatches++;
         if (!field_ok("len_out", SEQ_W'(w.len), SEQ_W'(rsp_len_out))) mismatches++;
         if (!field_ok("last", SEQ_W'(w.last), SEQ_W'(rsp_last))) mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = TIMEOUT_RESET;
         win_base      = SEQ_W'(1);
         seq_next      = SEQ_W'(1);
         final_seq     = '0;
         fin_sent      = 1'b0;
         fin_acked     = 1'b0;
         timer_on      = 1'b0;
         timer_left    = '0;
         mismatches    = 0;
         due.delete();
      end else begin
         if (csr_valid && csr_ready) timeout_ticks = csr_data;
         if (req_valid && !req_stall)
            step_window(req_func, req_payload_tag, req_payload_len, req_link_sel,
                        req_ack_seq, req_ack_good);
         if (rsp_valid && !rsp_stall) check_result();
      end
      owed      = due.size();
      base_seen = win_base;
      next_seen = seq_next;
   end

endmodule

// File: test/go_back_n_sender_window_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit_tb
// Drives packets, acks and ticks into the Go-Back-N sender under several
// timeout settings with bursty requests and a stalling receiver; the
// checker beside the block predicts and compares every transmission.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit_tb
   import gbn_pkg::*;
();

   localparam int HALF_PERIOD     = 4;
   localparam int SETTLE_CYCLES   = 40;   // queue of 4 plus a full resend walk
   localparam int LONG_HOLD       = 300;  // receiver hold-off, long enough to fill the queue
   localparam int ITEMS_PER_PHASE = 78;

   // func code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [FUNC_W-1:0] req_func        = FUNC_NEW;
   logic [TAG_W-1:0]  req_payload_tag = '0;
   logic [LEN_W-1:0]  req_payload_len = '0;
   logic              req_link_sel    = 1'b0;
   logic [SEQ_W-1:0]  req_ack_seq     = '0;
   logic              req_ack_good    = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [SEQ_W-1:0]  rsp_seq_out;
   logic              rsp_link_out;
   logic [TAG_W-1:0]  rsp_tag_out;
   logic [LEN_W-1:0]  rsp_len_out;
   logic              rsp_last;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   logic [TMR_W-1:0]  csr_data        = '0;

   int                mon_errors;
   int                owed;
   logic [SEQ_W-1:0]  win_base_now;
   logic [SEQ_W-1:0]  seq_next_now;

   // sender burst shaping (stimulus process only)
   int                burst_left = 0;
   bit                gaps_on    = 1'b1;

   // receiver hold-off requests: stimulus bumps holds_asked, receiver tracks holds_done
   int                holds_asked = 0;
   int                holds_done;
   int                hold_left;
   int                style_left;
   int                stall_style;
   int                cyc;

   logic [TMR_W-1:0]  phase_timeout [5] = '{16'd3, 16'd65535, 16'd1, 16'd7, 16'd1};

   always #HALF_PERIOD clock = ~clock;

   go_back_n_sender_window_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_payload_tag (req_payload_tag),
      .req_payload_len (req_payload_len),
      .req_link_sel    (req_link_sel),
      .req_ack_seq     (req_ack_seq),
      .req_ack_good    (req_ack_good),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_link_out    (rsp_link_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_len_out     (rsp_len_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   gbn_window_checker mon (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_payload_tag (req_payload_tag),
      .req_payload_len (req_payload_len),
      .req_link_sel    (req_link_sel),
      .req_ack_seq     (req_ack_seq),
      .req_ack_good    (req_ack_good),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_link_out    (rsp_link_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_len_out     (rsp_len_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatches      (mon_errors),
      .owed            (owed),
      .base_seen       (win_base_now),
      .next_seen       (seq_next_now)
   );

   // Receiver: picks stall styles at random (none, light, heavy, periodic). A
   // hold-off request overrides everything while hold_left counts down from
   // LONG_HOLD, backing up the output register and request queue until req_stall rises.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_left   <= 0;
         holds_done  <= 0;
         style_left  <= 0;
         stall_style <= 0;
         cyc         <= 0;
      end else begin
         cyc <= cyc + 1;
         if (hold_left != 0) begin
            rsp_stall <= (hold_left != 1);
            hold_left <= hold_left - 1;
         end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= LONG_HOLD;
            rsp_stall  <= 1'b1;
         end else begin
            if (style_left == 0) begin
               stall_style <= $urandom_range(0, 3);
               style_left  <= $urandom_range(20, 120);
            end else begin
               style_left <= style_left - 1;
            end
            case (stall_style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((cyc % 5) < 2);
            endcase
         end
      end
   end

   // One request: optional idle gap at a burst boundary, then hold the
   // request until the block takes it.
   task automatic issue_request(input logic [FUNC_W-1:0] f, input logic [TAG_W-1:0] tag,
                                input logic [LEN_W-1:0] len, input logic link,
                                input logic [SEQ_W-1:0] ack, input logic good);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) :
                                                    $urandom_range(0, 4);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid       <= 1'b1;
      req_func        <= f;
      req_payload_tag <= tag;
      req_payload_len <= len;
      req_link_sel    <= link;
      req_ack_seq     <= ack;
      req_ack_good    <= good;
      do @(posedge clock); while (req_stall);
   endtask

   // unused fields carry noise
   task automatic send_packet(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                              input logic link);
      issue_request(FUNC_NEW, tag, len, link, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_ack(input logic [SEQ_W-1:0] ack, input logic good);
      issue_request(FUNC_ACK, $urandom, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                    ack, good);
   endtask

   task automatic send_tick();
      issue_request(FUNC_TICK, $urandom, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                    $urandom, 1'($urandom_range(0, 1)));
   endtask

   // Stop sending and wait until every owed transmission is out, then settle
   // and wait again until nothing is owed.
   task automatic idle_until_drained();
      req_valid <= 1'b0;
      do begin
         while (owed != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (owed != 0);
   endtask

   task automatic write_timeout(input logic [TMR_W-1:0] ticks);
      idle_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic: in-window acks dominate so the window keeps
   // sliding; stale, just-beyond-window, random and corrupt acks mixed in.
   task automatic random_request();
      int               pick;
      int               r;
      logic [SEQ_W-1:0] span;
      logic [SEQ_W-1:0] ack;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 99);
      if (pick < 45) begin
         len = (r < 10) ? LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047)) :
                          LEN_W'($urandom_range(1, MAX_PAYLOAD));
         send_packet($urandom, len, 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
         span = seq_next_now - win_base_now;
         if (r < 70)      ack = win_base_now - 1 + $urandom_range(0, span);
         else if (r < 85) ack = seq_next_now + $urandom_range(0, 3);
         else             ack = $urandom;
         send_ack(ack, $urandom_range(0, 9) != 0);
      end else if (pick < 98) begin
         send_tick();
      end else begin
         issue_request(FUNC_SPARE, $urandom, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                       $urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [SEQ_W-1:0] fin_seq;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: zero timeout, so every running tick expires ----
      write_timeout(16'd0);
      send_tick();                                   // timer stopped: quiet
      send_packet(32'hFFFF_FFFF, LEN_W'(MAX_PAYLOAD), 1'b1);
      send_packet(32'h0000_0000, 11'h7FF, 1'b0);     // oversized, clipped
      send_tick();                                   // expiry: resend 1 and 2
      send_ack(32'hFFFF_FFFF, 1'b0);                 // corrupt ack
      send_ack(32'd0, 1'b1);                         // stale ack, base stays
      send_ack(32'd100, 1'b1);                       // ack beyond next_seq
      send_ack(32'd1, 1'b1);                         // base slides to 2
      issue_request(FUNC_SPARE, $urandom, LEN_W'($urandom), 1'b1, $urandom, 1'b1);
      repeat (15) send_packet($urandom, LEN_W'($urandom_range(1, MAX_PAYLOAD)),
                              1'($urandom_range(0, 1)));
      send_packet($urandom, 11'd1, 1'b1);            // window full: refused
      send_tick();                                   // full-window resend

      // ---- random phases over several timeout settings ----
      for (int p = 0; p < 5; p++) begin
         write_timeout(phase_timeout[p]);
         if (p == 2) begin
            // back-to-back requests while the receiver holds off
            holds_asked <= holds_asked + 1;
            gaps_on = 1'b0;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == 2 && k == 40) gaps_on = 1'b1;
            random_request();
         end
      end

      // ---- end of transfer: ack everything, send the final packet ----
      idle_until_drained();
      send_ack(seq_next_now - 1, 1'b1);
      idle_until_drained();
      fin_seq = seq_next_now;
      send_packet($urandom, 11'd0, 1'b1);            // final packet
      send_packet($urandom, 11'd8, 1'b0);            // refused after final
      send_tick();                                   // resend of final packet
      send_ack(fin_seq - 1, 1'b1);
      send_ack(fin_seq, 1'b0);                       // corrupt ack of final
      send_ack(fin_seq, 1'b1);                       // completion
      send_ack($urandom, 1'b1);                      // still complete
      send_tick();                                   // timer stopped for good
      send_packet($urandom, 11'd1, 1'b1);

      idle_until_drained();
      if (mon_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
src/gbn_pkg.sv
src/gbn_front.sv
src/gbn_cmd_queue.sv
src/gbn_back.sv
src/go_back_n_sender_window_unit.sv
test/gbn_window_checker.sv
test/go_back_n_sender_window_unit_tb.sv
